>>> rtl/npv_pkg.sv
// Package for the node path validator: item structs, status codes and byte constants.
// No dependencies; used by npv_step and node_path_validator_unit.
`default_nettype none

package npv_pkg;

    // Characters the scan looks for.
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Width of the reported error position.
    localparam int unsigned EPOS_W = 12;

    // Verdict codes; ST_OK also means "no scan error held".
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NO_LEAD    = 3'd2,
        ST_TRAIL      = 3'd3,
        ST_NULL       = 3'd4,
        ST_EMPTY_NODE = 3'd5,
        ST_RELATIVE   = 3'd6
    } status_t;

    // One input item.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_last;
        logic       end_only;
        logic       sequential;
    } in_item_t;

    // One result item.
    typedef struct packed {
        status_t             status;
        logic [EPOS_W-1:0]   error_position;
    } out_item_t;

    // Scan state apart from the byte count.
    typedef struct packed {
        logic [7:0]          prev_byte;
        logic [7:0]          prev_prev_byte;
        logic                first_byte_bad;
        logic                pending_dot;
        logic [EPOS_W-1:0]   pending_dot_position;
        status_t             scan_error_code;
        logic [EPOS_W-1:0]   scan_error_position;
    } scan_state_t;

    // Scan state after reset and after each path end.
    localparam scan_state_t SCAN_RESET = '{
        prev_byte:            CH_SLASH,
        prev_prev_byte:       CH_NUL,
        first_byte_bad:       1'b0,
        pending_dot:          1'b0,
        pending_dot_position: '0,
        scan_error_code:      ST_OK,
        scan_error_position:  '0
    };

endpackage

`default_nettype wire

>>> rtl/npv_step.sv
// Combinational scan of one path byte: updates the neighbor bytes, pending dot and first error.
// Depends on npv_pkg.
`default_nettype none

module npv_step
    import npv_pkg::*;
#(
    parameter int unsigned MAX_PATH_LEN = 4096,
    parameter int unsigned POS_W        = 13
) (
    input  wire scan_state_t        state_in,
    input  wire logic [POS_W-1:0]   pos_in,
    input  wire logic [7:0]         char_in,
    output      scan_state_t        state_out,
    output      logic [POS_W-1:0]   pos_out
);

    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_PATH_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_PATH_LEN - 1);

    logic                 below_max;
    logic [POS_W-1:0]     idx_full;
    logic [EPOS_W-1:0]    idx;

    // Index of this byte; saturates at the last legal position.
    assign below_max = (pos_in < POS_MAX);
    assign idx_full  = below_max ? pos_in : POS_LAST;
    assign idx       = EPOS_W'(idx_full);
    assign pos_out   = below_max ? (pos_in + POS_W'(1)) : pos_in;

    // Scan rules; the first error found is kept.
    always_comb begin
        scan_state_t s;
        logic        comp;
        s    = state_in;
        comp = 1'b0;
        if (pos_in == '0) begin
            s.first_byte_bad = (char_in != CH_SLASH);
        end else if (s.scan_error_code == ST_OK) begin
            // A pending dot closes a relative component when a slash follows.
            if (s.pending_dot) begin
                if (char_in == CH_SLASH) begin
                    s.scan_error_code     = ST_RELATIVE;
                    s.scan_error_position = s.pending_dot_position;
                end
                s.pending_dot = 1'b0;
            end
            if (s.scan_error_code == ST_OK) begin
                if (char_in == CH_NUL) begin
                    s.scan_error_code     = ST_NULL;
                    s.scan_error_position = idx;
                end else if (char_in == CH_SLASH && state_in.prev_byte == CH_SLASH) begin
                    s.scan_error_code     = ST_EMPTY_NODE;
                    s.scan_error_position = idx;
                end else if (char_in == CH_DOT) begin
                    comp = (state_in.prev_byte == CH_DOT) ?
                           (state_in.prev_prev_byte == CH_SLASH) :
                           (state_in.prev_byte == CH_SLASH);
                    if (comp) begin
                        s.pending_dot          = 1'b1;
                        s.pending_dot_position = idx;
                    end
                end
            end
        end
        s.prev_prev_byte = state_in.prev_byte;
        s.prev_byte      = char_in;
        state_out        = s;
    end

endmodule

`default_nettype wire

>>> rtl/node_path_validator_unit.sv
// Top level of the node path validator: state registers, end-of-path verdict, output skid buffer.
// Depends on npv_pkg and npv_step.
//
//  Channel   Ports                       Moves
//  input     s_valid, s_ready, s_item    one path byte or a bare end marker per item
//  result    m_valid, m_ready, m_item    one verdict per path, after its final item
//
// One item is accepted per cycle while s_ready is high; its verdict is registered.
// The whole scan, including the appended '1' in sequential mode, is one combinational pass.
// Reset (aresetn low at a clock edge) clears the scan state and empties both result entries.
// A two-entry result buffer keeps s_ready high while one verdict waits on m_ready;
// s_ready drops only when both entries are full.
`default_nettype none

module node_path_validator_unit
    import npv_pkg::*;
#(
    parameter int unsigned MAX_PATH_LEN = 4096
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output      logic      s_ready,
    input  wire in_item_t  s_item,
    output      logic      m_valid,
    input  wire logic      m_ready,
    output      out_item_t m_item
);

    localparam int unsigned POS_W = $clog2(MAX_PATH_LEN + 1);

    scan_state_t          state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    out_item_t            main_reg, main_next;
    out_item_t            skid_reg, skid_next;
    logic                 main_valid_reg, main_valid_next;
    logic                 skid_valid_reg, skid_valid_next;

    scan_state_t          byte_state, seq_state, mid_state, end_state;
    logic [POS_W-1:0]     byte_pos, seq_pos, mid_pos, end_pos;
    logic                 in_fire, out_fire, path_done, res_valid;
    out_item_t            result;

    assign in_fire   = s_valid && s_ready;
    assign out_fire  = main_valid_reg && m_ready;
    assign path_done = s_item.end_only || s_item.is_last;
    assign res_valid = in_fire && path_done;

    // Scan of the received byte.
    npv_step #(.MAX_PATH_LEN(MAX_PATH_LEN), .POS_W(POS_W)) u_byte_step (
        .state_in  (state_reg),
        .pos_in    (pos_reg),
        .char_in   (s_item.char_byte),
        .state_out (byte_state),
        .pos_out   (byte_pos)
    );

    // A bare end marker adds no byte.
    assign mid_state = s_item.end_only ? state_reg : byte_state;
    assign mid_pos   = s_item.end_only ? pos_reg   : byte_pos;

    // Scan of the virtual '1' appended in sequential mode.
    npv_step #(.MAX_PATH_LEN(MAX_PATH_LEN), .POS_W(POS_W)) u_seq_step (
        .state_in  (mid_state),
        .pos_in    (mid_pos),
        .char_in   (CH_ONE),
        .state_out (seq_state),
        .pos_out   (seq_pos)
    );

    // Verdict from the state at path end; header checks win over scan errors.
    always_comb begin
        scan_state_t e;
        e = s_item.sequential ? seq_state : mid_state;
        if (e.scan_error_code == ST_OK && e.pending_dot) begin
            e.scan_error_code     = ST_RELATIVE;
            e.scan_error_position = e.pending_dot_position;
        end
        end_state = e;
    end

    assign end_pos = s_item.sequential ? seq_pos : mid_pos;

    always_comb begin
        result.status         = ST_OK;
        result.error_position = '0;
        if (end_pos == '0) begin
            result.status = ST_EMPTY;
        end else if (end_state.first_byte_bad) begin
            result.status = ST_NO_LEAD;
        end else if (end_pos == POS_W'(1)) begin
            result.status = ST_OK;
        end else if (end_state.prev_byte == CH_SLASH) begin
            result.status = ST_TRAIL;
        end else if (end_state.scan_error_code != ST_OK) begin
            result.status         = end_state.scan_error_code;
            result.error_position = end_state.scan_error_position;
        end
    end

    // Scan state: advance on each byte, clear at path end.
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        if (in_fire) begin
            if (path_done) begin
                state_next = SCAN_RESET;
                pos_next   = '0;
            end else begin
                state_next = byte_state;
                pos_next   = byte_pos;
            end
        end
    end

    // Result buffer: main entry drives the port, skid entry catches a verdict under stall.
    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (out_fire) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!main_valid_reg || out_fire) begin
            main_valid_next = res_valid;
            main_next       = result;
        end else if (res_valid) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SCAN_RESET;
            pos_reg        <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign s_ready = !skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_item  = main_reg;

    // The skid entry is only filled behind a waiting main entry.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry holds a verdict while the main entry is empty");

    // Every path end leaves the scan state cleared for the next path.
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_item.end_only || s_item.is_last))
        |=> (pos_reg == '0 && state_reg == SCAN_RESET))
        else $error("scan state not cleared after path end");

    // Header verdicts carry no error position.
    a_header_no_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && (main_reg.status == ST_OK || main_reg.status == ST_EMPTY ||
                            main_reg.status == ST_NO_LEAD || main_reg.status == ST_TRAIL))
        |-> (main_reg.error_position == '0))
        else $error("error position set on a verdict without a scan error");

endmodule

`default_nettype wire
